>>> rtl/imuq_pkg.sv
// Shared constants and types for the IMU quaternion remap and normalize block.
package imuq_pkg;

  localparam int NUM_COMP   = 4;
  localparam int OUT_W      = 16;
  localparam int FRAC_BITS  = 14;
  localparam int QUOT_W     = FRAC_BITS + 1;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;
  localparam int MIN_MAG_W  = 8;

  localparam logic [QUOT_W-1:0]     UNIT_Q      = QUOT_W'(1 << FRAC_BITS);
  localparam logic [MIN_MAG_W-1:0]  MIN_MAG_RST = MIN_MAG_W'(16);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HAND_SIDE = 8'd0,
    CFG_MIN_MAG   = 8'd1
  } cfg_idx_e;

  typedef enum logic {
    HAND_RIGHT = 1'b0,
    HAND_LEFT  = 1'b1
  } hand_e;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctrl_t;

endpackage

>>> rtl/imuq_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband payload.
module imuq_sqrt import imuq_pkg::*; #(
  parameter int IN_W   = 34,
  parameter int SIDE_W = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pipe_ctrl_t         ctrl_i,
  input  logic [IN_W-1:0]    rad_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               vld_o,
  output logic [IN_W/2-1:0]  root_o,
  output logic [SIDE_W-1:0]  side_o
);

  localparam int S  = IN_W / 2;
  localparam int RW = S + 2;

  logic              vld_q  [S];
  logic [IN_W-1:0]   n_q    [S];
  logic [RW-1:0]     r_q    [S];
  logic [S-1:0]      q_q    [S];
  logic [SIDE_W-1:0] side_q [S];

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic              vld_in;
    logic [IN_W-1:0]   n_in;
    logic [RW-1:0]     r_in;
    logic [S-1:0]      q_in;
    logic [SIDE_W-1:0] side_in;
    logic [RW+1:0]     r_sh;
    logic [RW+1:0]     trial;
    logic [RW-1:0]     r_d;
    logic [S-1:0]      q_d;

    if (k == 0) begin : g_first
      assign vld_in  = ctrl_i.vld;
      assign n_in    = rad_i;
      assign r_in    = '0;
      assign q_in    = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign n_in    = n_q[k-1];
      assign r_in    = r_q[k-1];
      assign q_in    = q_q[k-1];
      assign side_in = side_q[k-1];
    end

    always_comb begin
      r_sh  = {r_in, n_in[IN_W-1 -: 2]};
      trial = (RW+2)'({q_in, 2'b01});
      if (r_sh >= trial) begin
        r_d = RW'(r_sh - trial);
        q_d = {q_in[S-2:0], 1'b1};
      end else begin
        r_d = RW'(r_sh);
        q_d = {q_in[S-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctrl_i.en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        n_q[k]    <= n_in << 2;
        r_q[k]    <= r_d;
        q_q[k]    <= q_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[S-1];
  assign root_o = q_q[S-1];
  assign side_o = side_q[S-1];

endmodule

>>> rtl/imuq_div.sv
// Pipelined four-lane restoring divider: round(|c| * 2^14 / mag), one bit per stage.
module imuq_div import imuq_pkg::*; #(
  parameter int CW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pipe_ctrl_t           ctrl_i,
  input  logic signed [CW-1:0] c_i [NUM_COMP],
  input  logic [CW:0]          mag_i,
  output logic                 vld_o,
  output logic [QUOT_W-1:0]    q_o [NUM_COMP],
  output logic signed [CW-1:0] c_o [NUM_COMP],
  output logic [CW:0]          mag_o
);

  localparam int DW = CW + FRAC_BITS + 1;
  localparam int NS = QUOT_W;

  logic                 vld_q [NS];
  logic [CW:0]          mag_q [NS];
  logic signed [CW-1:0] c_q   [NS][NUM_COMP];
  logic [CW:0]          r_q   [NS][NUM_COMP];
  logic [QUOT_W-1:0]    lo_q  [NS][NUM_COMP];
  logic [QUOT_W-1:0]    qt_q  [NS][NUM_COMP];

  logic [CW:0]       r0  [NUM_COMP];
  logic [QUOT_W-1:0] lo0 [NUM_COMP];

  always_comb begin
    logic [CW-1:0] a;
    logic [DW-1:0] dvd;
    for (int l = 0; l < NUM_COMP; l++) begin
      a      = c_i[l][CW-1] ? CW'(-c_i[l]) : CW'(c_i[l]);
      dvd    = (DW'(a) << FRAC_BITS) + DW'(mag_i >> 1);
      r0[l]  = (CW+1)'(dvd[DW-1:QUOT_W]);
      lo0[l] = dvd[QUOT_W-1:0];
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic                 vld_in;
    logic [CW:0]          mag_in;
    logic signed [CW-1:0] c_in  [NUM_COMP];
    logic [CW:0]          r_in  [NUM_COMP];
    logic [QUOT_W-1:0]    lo_in [NUM_COMP];
    logic [QUOT_W-1:0]    qt_in [NUM_COMP];
    logic [CW:0]          r_d   [NUM_COMP];
    logic [QUOT_W-1:0]    qt_d  [NUM_COMP];

    if (k == 0) begin : g_first
      assign vld_in = ctrl_i.vld;
      assign mag_in = mag_i;
      assign c_in   = c_i;
      assign r_in   = r0;
      assign lo_in  = lo0;
      assign qt_in  = '{default: '0};
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign mag_in = mag_q[k-1];
      assign c_in   = c_q[k-1];
      assign r_in   = r_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign qt_in  = qt_q[k-1];
    end

    always_comb begin
      logic [CW+1:0] r_sh;
      for (int l = 0; l < NUM_COMP; l++) begin
        r_sh = {r_in[l], lo_in[l][QUOT_W-1]};
        if (r_sh >= (CW+2)'(mag_in)) begin
          r_d[l]  = (CW+1)'(r_sh - (CW+2)'(mag_in));
          qt_d[l] = {qt_in[l][QUOT_W-2:0], 1'b1};
        end else begin
          r_d[l]  = (CW+1)'(r_sh);
          qt_d[l] = {qt_in[l][QUOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ctrl_i.en) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en) begin
        mag_q[k] <= mag_in;
        c_q[k]   <= c_in;
        r_q[k]   <= r_d;
        qt_q[k]  <= qt_d;
        for (int l = 0; l < NUM_COMP; l++) begin
          lo_q[k][l] <= lo_in[l] << 1;
        end
      end
    end
  end

  assign vld_o = vld_q[NS-1];
  assign q_o   = qt_q[NS-1];
  assign c_o   = c_q[NS-1];
  assign mag_o = mag_q[NS-1];

endmodule

>>> rtl/imu_quaternion_remap_normalize.sv
// Top level: IMU quaternion axis remap, magnitude and normalization pipeline.
// Throughput: one transaction per cycle; the whole pipeline advances together
// and holds while the output register is full and stalled.
// The depth is set by the square root (one root bit per stage) and the
// divider (one quotient bit per stage). Reset clears valid bits and sets config to defaults.
module imu_quaternion_remap_normalize import imuq_pkg::*; #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              sample_valid_i,
  input  logic signed [COMPONENT_WIDTH-1:0] in_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0] in_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] in_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] in_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [OUT_W-1:0]           out_w_o,
  output logic signed [OUT_W-1:0]           out_x_o,
  output logic signed [OUT_W-1:0]           out_y_o,
  output logic signed [OUT_W-1:0]           out_z_o,
  output logic                              was_normalized_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [CFG_DATA_W-1:0]             cfg_data_i
);

  localparam int CW   = COMPONENT_WIDTH;
  localparam int SUMW = 2 * CW + 2;
  localparam int SQW  = 2 * CW;
  localparam bit SAT_SUM = (SQW >= 64);
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};

  hand_e                hand_q;
  logic [MIN_MAG_W-1:0] min_mag_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hand_q    <= HAND_RIGHT;
      min_mag_q <= MIN_MAG_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_HAND_SIDE: hand_q    <= hand_e'(cfg_data_i[0]);
        CFG_MIN_MAG:   min_mag_q <= cfg_data_i[MIN_MAG_W-1:0];
        default: ;
      endcase
    end
  end

  logic       out_vld_q;
  logic       en;
  pipe_ctrl_t sqrt_ctrl, div_ctrl;

  assign en         = !out_vld_q || !out_stall_i;
  assign in_stall_o = !en;

  function automatic logic signed [CW-1:0] neg_sat(input logic signed [CW-1:0] v);
    return (v == C_MIN) ? C_MAX : -v;
  endfunction

  // stage A: remap
  logic                 a_vld_q;
  logic signed [CW-1:0] a_c_q [NUM_COMP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i && sample_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_c_q[0] <= in_w_i;
      a_c_q[2] <= in_z_i;
      if (hand_q == HAND_RIGHT) begin
        a_c_q[1] <= neg_sat(in_y_i);
        a_c_q[3] <= neg_sat(in_x_i);
      end else begin
        a_c_q[1] <= in_y_i;
        a_c_q[3] <= in_x_i;
      end
    end
  end

  // stage B: squares
  logic                 b_vld_q;
  logic signed [CW-1:0] b_c_q  [NUM_COMP];
  logic [SQW-1:0]       b_sq_q [NUM_COMP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (en) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [CW-1:0] a;
    if (en) begin
      for (int l = 0; l < NUM_COMP; l++) begin
        a         = a_c_q[l][CW-1] ? CW'(-a_c_q[l]) : CW'(a_c_q[l]);
        b_sq_q[l] <= SQW'(a) * SQW'(a);
        b_c_q[l]  <= a_c_q[l];
      end
    end
  end

  // stage C: sum of squares
  logic                 c_vld_q;
  logic signed [CW-1:0] c_c_q [NUM_COMP];
  logic [SUMW-1:0]      c_sum_q;
  logic [SUMW-1:0]      sum_d;

  always_comb begin
    sum_d = SUMW'(b_sq_q[0]) + SUMW'(b_sq_q[1]) + SUMW'(b_sq_q[2]) + SUMW'(b_sq_q[3]);
    if (SAT_SUM && sum_d[SQW]) begin
      sum_d = SUMW'({SQW{1'b1}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_sum_q <= sum_d;
      c_c_q   <= b_c_q;
    end
  end

  // square root
  logic [NUM_COMP*CW-1:0] c_pack, s_pack;
  logic                   s_vld;
  logic [CW:0]            s_mag;
  logic signed [CW-1:0]   s_c [NUM_COMP];

  always_comb begin
    for (int l = 0; l < NUM_COMP; l++) begin
      c_pack[l*CW +: CW] = c_c_q[l];
      s_c[l]             = s_pack[l*CW +: CW];
    end
  end

  assign sqrt_ctrl = '{en: en, vld: c_vld_q};

  imuq_sqrt #(
    .IN_W   (SUMW),
    .SIDE_W (NUM_COMP * CW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (sqrt_ctrl),
    .rad_i  (c_sum_q),
    .side_i (c_pack),
    .vld_o  (s_vld),
    .root_o (s_mag),
    .side_o (s_pack)
  );

  // divide
  logic                 d_vld;
  logic [QUOT_W-1:0]    d_q [NUM_COMP];
  logic signed [CW-1:0] d_c [NUM_COMP];
  logic [CW:0]          d_mag;

  assign div_ctrl = '{en: en, vld: s_vld};

  imuq_div #(
    .CW (CW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .c_i    (s_c),
    .mag_i  (s_mag),
    .vld_o  (d_vld),
    .q_o    (d_q),
    .c_o    (d_c),
    .mag_o  (d_mag)
  );

  // output register
  logic                    norm;
  logic                    out_norm_q;
  logic signed [OUT_W-1:0] out_d [NUM_COMP];
  logic signed [OUT_W-1:0] out_q [NUM_COMP];

  assign norm = d_mag > (CW+1)'(min_mag_q);

  always_comb begin
    logic [QUOT_W-1:0] qc;
    for (int l = 0; l < NUM_COMP; l++) begin
      qc = (d_q[l] > UNIT_Q) ? UNIT_Q : d_q[l];
      if (norm) begin
        out_d[l] = d_c[l][CW-1] ? -OUT_W'(qc) : OUT_W'(qc);
      end else begin
        out_d[l] = OUT_W'(d_c[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q      <= out_d;
      out_norm_q <= norm;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_w_o          = out_q[0];
  assign out_x_o          = out_q[1];
  assign out_y_o          = out_q[2];
  assign out_z_o          = out_q[3];
  assign was_normalized_o = out_norm_q;

  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_normalized_o |->
      out_w_o <= 16'sd16384 && out_w_o >= -16'sd16384 &&
      out_x_o <= 16'sd16384 && out_x_o >= -16'sd16384)
    else $error("normalized component out of range");

  a_pass_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !was_normalized_o |->
      out_w_o <= 16'sd255 && out_w_o >= -16'sd255 &&
      out_z_o <= 16'sd255 && out_z_o >= -16'sd255)
    else $error("pass-through component exceeds threshold range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output");

  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> out_valid_o)
    else $error("output transaction lost while pipeline held");

endmodule

>>> bench/imuq_checker.sv
// Checker: watches sample, config and result channels; predicts and checks quaternion results.
module imuq_checker import imuq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic                    sample_valid_i,
  input  logic signed [15:0]      in_w_i,
  input  logic signed [15:0]      in_x_i,
  input  logic signed [15:0]      in_y_i,
  input  logic signed [15:0]      in_z_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [OUT_W-1:0] out_w_i,
  input  logic signed [OUT_W-1:0] out_x_i,
  input  logic signed [OUT_W-1:0] out_y_i,
  input  logic signed [OUT_W-1:0] out_z_i,
  input  logic                    was_normalized_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output int                      errors_o,
  output int                      pending_o,
  output int                      results_o,
  output int                      norm_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EXP_DEPTH = 64;

  typedef struct packed {
    logic signed [15:0] w, x, y, z;
    logic               norm;
  } quat_t;

  quat_t      exp_mem [EXP_DEPTH];
  logic [5:0] exp_wr;
  logic [5:0] exp_rd;
  int         exp_count;
  hand_e      hand;
  logic [7:0] min_mag;

  function automatic longint neg_clip(longint v);
    return (v == -32768) ? 32767 : -v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic quat_t remap_normalize(longint w, longint x, longint y, longint z);
    longint c[4];
    longint unsigned a, sum, mag, q;
    logic norm;
    quat_t r;
    c[0] = w;
    c[2] = z;
    c[1] = (hand == HAND_RIGHT) ? neg_clip(y) : y;
    c[3] = (hand == HAND_RIGHT) ? neg_clip(x) : x;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      a = (c[i] < 0) ? -c[i] : c[i];
      sum += a * a;
    end
    mag = root_floor(sum);
    norm = mag > min_mag;
    if (norm) begin
      for (int i = 0; i < 4; i++) begin
        a = (c[i] < 0) ? -c[i] : c[i];
        q = ((a << FRAC_BITS) + (mag >> 1)) / mag;
        if (q > (1 << FRAC_BITS)) q = 1 << FRAC_BITS;
        c[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    r.w = c[0][15:0];
    r.x = c[1][15:0];
    r.y = c[2][15:0];
    r.z = c[3][15:0];
    r.norm = norm;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    quat_t e;
    if (!rst_ni) begin
      hand <= HAND_RIGHT;
      min_mag <= MIN_MAG_RST;
      errors_o = 0;
      results_o = 0;
      norm_seen_o = 0;
      exp_wr = '0;
      exp_rd = '0;
      exp_count = 0;
    end else begin
      if (in_valid_i && !in_stall_i && sample_valid_i) begin
        if (exp_count == EXP_DEPTH) begin
          $error("expected-result store overflow");
          errors_o++;
        end else begin
          exp_mem[exp_wr] = remap_normalize(longint'(in_w_i), longint'(in_x_i),
                                            longint'(in_y_i), longint'(in_z_i));
          exp_wr = exp_wr + 6'd1;
          exp_count++;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (exp_count == 0) begin
          $error("result transaction with nothing expected");
          errors_o++;
        end else begin
          e = exp_mem[exp_rd];
          exp_rd = exp_rd + 6'd1;
          exp_count--;
          if (e.norm) norm_seen_o++;
          if (out_w_i !== e.w) begin
            $error("out_w expected %0d got %0d", e.w, out_w_i); errors_o++;
          end
          if (out_x_i !== e.x) begin
            $error("out_x expected %0d got %0d", e.x, out_x_i); errors_o++;
          end
          if (out_y_i !== e.y) begin
            $error("out_y expected %0d got %0d", e.y, out_y_i); errors_o++;
          end
          if (out_z_i !== e.z) begin
            $error("out_z expected %0d got %0d", e.z, out_z_i); errors_o++;
          end
          if (was_normalized_i !== e.norm) begin
            $error("was_normalized expected %0d got %0d", e.norm, was_normalized_i);
            errors_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_HAND_SIDE) hand <= hand_e'(cfg_data_i[0]);
        else if (cfg_index_i == CFG_MIN_MAG) min_mag <= cfg_data_i;
      end
    end
  end

  assign pending_o = exp_count;
endmodule

>>> bench/imu_quaternion_remap_normalize_test.sv
// Testbench top: drives samples and config writes into the quaternion block and reports the verdict.
module imu_quaternion_remap_normalize_test import imuq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 16 + 20;
  localparam int WATCHDOG = 5000;

  logic clk_i, rst_ni;
  logic in_valid, in_stall, sample_valid;
  logic signed [15:0] in_w, in_x, in_y, in_z;
  logic out_valid, out_stall;
  logic signed [OUT_W-1:0] out_w, out_x, out_y, out_z;
  logic was_normalized;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int errors, pending, results, norm_seen;
  int idle_cycles, sent;
  bit calm;

  imu_quaternion_remap_normalize #(.COMPONENT_WIDTH(16)) dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .sample_valid_i(sample_valid),
    .in_w_i(in_w), .in_x_i(in_x), .in_y_i(in_y), .in_z_i(in_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_w_o(out_w), .out_x_o(out_x), .out_y_o(out_y), .out_z_o(out_z),
    .was_normalized_o(was_normalized),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  imuq_checker checker_u (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .sample_valid_i(sample_valid),
    .in_w_i(in_w), .in_x_i(in_x), .in_y_i(in_y), .in_z_i(in_z),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_w_i(out_w), .out_x_i(out_x), .out_y_i(out_y), .out_z_i(out_z),
    .was_normalized_i(was_normalized),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .results_o(results), .norm_seen_o(norm_seen)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("FAIL imu_quaternion_remap_normalize");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic send(int v, int w, int x, int y, int z);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sample_valid <= v[0];
    in_w <= 16'(w); in_x <= 16'(x); in_y <= 16'(y); in_z <= 16'(z);
    do @(posedge clk_i); while (in_stall);
    sent++;
  endtask

  function automatic int rnd_comp(int sel);
    unique case (sel)
      0: return int'($urandom_range(40)) - 20;
      1: return int'($urandom_range(600)) - 300;
      2: return $urandom_range(1) ? -32768 : 32767;
      default: return int'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    int s;
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(3);
      send(int'($urandom_range(99) < 85), rnd_comp(s), rnd_comp(s),
           rnd_comp($urandom_range(3)), rnd_comp(s));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_ni = 0;
    in_valid = 0; sample_valid = 0;
    in_w = 0; in_x = 0; in_y = 0; in_z = 0;
    cfg_valid = 0; cfg_index = CFG_HAND_SIDE; cfg_data = 0;
    calm = 1; sent = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send(1, 16384, 0, 0, 0);
    send(1, 0, 0, 0, 0);
    send(0, 100, 200, 300, 400);
    send(1, -32768, -32768, -32768, -32768);
    send(1, 32767, 32767, 32767, 32767);
    send(1, 0, -32768, -32768, 0);
    send(1, 16, 0, 0, 0);
    send(1, 17, 0, 0, 0);
    send(1, -5, 3, -7, 2);
    send(1, 8192, -8192, 8192, -8192);
    send(1, 1, 1, 1, 32767);
    in_valid <= 1'b0;
    drain();
    write_reg(CFG_HAND_SIDE, 8'd1);
    write_reg(CFG_MIN_MAG, 8'd255);
    send(1, -32768, 0, -32768, 0);
    send(1, 255, 0, 0, 0);
    send(1, 256, 0, 0, 0);
    send(1, -100, 100, -100, 100);
    send(1, 12000, -9000, 300, -4);
    in_valid <= 1'b0;
    drain();
    write_reg(CFG_MIN_MAG, 8'd0);
    send(1, 0, 0, 0, 0);
    send(1, 0, 0, 0, 1);
    send(1, -1, 0, 0, 0);
    in_valid <= 1'b0;

    calm = 0;
    random_phase(200);
    drain();
    write_reg(CFG_HAND_SIDE, 8'd0);
    write_reg(CFG_MIN_MAG, 8'd16);
    random_phase(250);
    drain();
    write_reg(CFG_MIN_MAG, 8'd255);
    calm = 1;
    random_phase(200);
    calm = 0;
    drain();
    write_reg(CFG_HAND_SIDE, 8'd1);
    write_reg(CFG_MIN_MAG, 8'($urandom_range(255)));
    random_phase(300);
    drain();
    repeat (LATENCY) @(posedge clk_i);

    $display("Sent %0d samples over several hand/threshold settings; %0d results, %0d normalized.",
             sent, results, norm_seen);
    if (errors == 0 && pending == 0) begin
      $display("PASS imu_quaternion_remap_normalize");
    end else begin
      $display("FAIL imu_quaternion_remap_normalize");
    end
    $finish;
  end
endmodule
